// ----- rtl/rgblab_pkg.sv -----
// ----------------------------------------------------------------------------
// rgblab_pkg: shared constants and types of the sRGB to CIELAB converter
// Holds the stage map of the pipeline, the matrix and divider constants,
// the cube root stage record and the gamma lookup table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package rgblab_pkg;

  // Pipeline stage map
  localparam int N_STAGES = 25;
  localparam int ST_LIN   = 0;   // gamma lookup
  localparam int ST_PROD  = 1;   // matrix products
  localparam int ST_SUM   = 2;   // matrix sums, rounded to Q16
  localparam int ST_CR0   = 3;   // first cube root step
  localparam int CR_STEPS = 17;  // one result bit per step
  localparam int ST_FIN   = ST_CR0 + CR_STEPS;  // cube root rounding, branch select
  localparam int ST_DIFF  = ST_FIN + 1;         // f differences
  localparam int ST_MUL   = ST_FIN + 2;         // scale by 116 / 500 / 200
  localparam int ST_RND   = ST_FIN + 3;         // round to output format
  localparam int ST_OUT   = ST_FIN + 4;         // clamp / saturate, output register

  // RGB to normalized XYZ, Q0.16, white point already folded in
  localparam logic [15:0] MAT_Q16 [3][3] = '{
    '{16'd28435, 16'd24657, 16'd12446},
    '{16'd13933, 16'd46871, 16'd4732},
    '{16'd1162,  16'd7175,  16'd57210}
  };

  // Below this Q16 value f() is the linear segment
  localparam logic [16:0] LIN_LIMIT = 17'd581;

  // Linear segment: f = floor((225823*n + 262158500) / 29000)
  localparam logic [28:0] LIN_SLOPE  = 29'd225823;
  localparam logic [28:0] LIN_OFFSET = 29'd262158500;
  // Reciprocal of 29000 scaled by 2^44, rounded up
  localparam logic [29:0] LIN_RECIP  = 30'd606627105;
  localparam int          LIN_RSHIFT = 44;

  // Upper bound of f() over the whole input range
  localparam logic [16:0] F_MAX = 17'd65541;

  // One lane of the cube root: partial root, its square and the remainder
  typedef struct packed {
    logic        sel;   // linear segment applies
    logic [16:0] y;
    logic [33:0] y2;
    logic [51:0] rem;
  } cr_t;

  typedef logic [255:0][15:0] gamma_lut_t;

  // Fifth power in Q30 with truncating products
  function automatic longint unsigned pow5_q30(input longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  // Linear light of one 8-bit code in Q0.16
  function automatic logic [15:0] gamma_lin(input int unsigned code);
    longint unsigned n;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned y;
    if (code <= 10) begin
      return 16'((longint'(code) * 6553600 + 164730) / 329460);
    end
    n  = longint'(code) * 1000 + 14025;
    t  = ((n << 30) + 134512) / 269025;
    t2 = (t * t + (64'd1 << 29)) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      if (pow5_q30(mid) <= t2) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    y = (t2 * lo + (64'd1 << 43)) >> 44;
    return (y > 65535) ? 16'hFFFF : 16'(y);
  endfunction

  function automatic gamma_lut_t build_gamma_lut();
    gamma_lut_t lut;
    for (int c = 0; c < 256; c++) begin
      lut[c] = gamma_lin(c);
    end
    return lut;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rgb_to_lab_converter_unit.sv -----
// ----------------------------------------------------------------------------
// rgb_to_lab_converter_unit: 8-bit sRGB pixel to CIELAB (D65)
// Gamma table, 3x3 matrix, CIE f() by a bit-per-stage cube root, then
// L*, a*, b* scaled, rounded and clamped to fixed point.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while pix_ready is high and returns one Lab
// beat per pixel, in order. The pipeline holds the 17 cube root steps (one
// root bit each) plus the gamma, matrix and output scaling stages. Every
// stage holds its own valid bit and empty stages fill while the output
// waits, so pix_ready stays high as long as any stage ahead is free or
// lab_ready is high. L* is unsigned Q7.OUT_FRAC_BITS clamped to 0..100;
// a* and b* are signed and saturate to 16 bits.
`default_nettype none

module rgb_to_lab_converter_unit
  import rgblab_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  // pixel channel
  input  logic                pix_valid,
  output logic                pix_ready,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  // Lab channel
  output logic                lab_valid,
  input  logic                lab_ready,
  output logic [14:0]         lightness,
  output logic signed [15:0]  green_red_axis,
  output logic signed [15:0]  blue_yellow_axis
);

  localparam gamma_lut_t GAMMA_LUT = build_gamma_lut();

  localparam int                RND_SHIFT = 16 - OUT_FRAC_BITS;
  localparam logic [26:0]       RND_HALF  = 27'(1) << (RND_SHIFT - 1);
  localparam logic signed [26:0] L_MAX    = 27'(100) << OUT_FRAC_BITS;

  // Round Q16 to the output format, halves away from zero
  function automatic logic signed [26:0] round_q(input logic signed [26:0] v);
    logic [26:0] mag;
    logic [26:0] r;
    mag = v[26] ? 27'(-v) : 27'(v);
    r   = (mag + RND_HALF) >> RND_SHIFT;
    return v[26] ? $signed(27'(-r)) : $signed(r);
  endfunction

  // --------------------------------------------------------------------------
  // Stage control: a stage moves when it or any stage after it is empty,
  // or when the output beat is taken
  // --------------------------------------------------------------------------
  logic [N_STAGES-1:0] vld;
  logic [N_STAGES-1:0] en;

  always_comb begin
    for (int i = 0; i < N_STAGES; i++) begin
      en[i] = lab_ready | ~(&(vld | N_STAGES'((32'd1 << i) - 32'd1)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < N_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= (i == 0) ? pix_valid : vld[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign pix_ready = en[ST_LIN];
  assign lab_valid = vld[ST_OUT];

  // --------------------------------------------------------------------------
  // Gamma lookup
  // --------------------------------------------------------------------------
  logic [15:0] lin [3];

  always_ff @(posedge clk) begin
    if (en[ST_LIN]) begin
      lin[0] <= GAMMA_LUT[red];
      lin[1] <= GAMMA_LUT[green];
      lin[2] <= GAMMA_LUT[blue];
    end
  end

  // --------------------------------------------------------------------------
  // Matrix products, then row sums rounded to Q16
  // --------------------------------------------------------------------------
  logic [31:0] prod [3][3];
  logic [16:0] xyz  [3];

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= 32'(lin[c]) * 32'(MAT_Q16[r][c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      for (int r = 0; r < 3; r++) begin
        xyz[r] <= 17'((33'(prod[r][0]) + 33'(prod[r][1]) + 33'(prod[r][2])
                       + 33'd32768) >> 16);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cube root, one bit per stage, MSB first
  // --------------------------------------------------------------------------
  cr_t cr_init [3];
  cr_t cr_q    [CR_STEPS][3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cr_init[c].sel = (xyz[c] < LIN_LIMIT);
      cr_init[c].y   = '0;
      cr_init[c].y2  = '0;
      cr_init[c].rem = {3'b000, xyz[c], 32'd0};
    end
  end

  for (genvar j = 0; j < CR_STEPS; j++) begin : g_cr
    localparam int K = CR_STEPS - 1 - j;
    for (genvar c = 0; c < 3; c++) begin : g_ch
      cr_t         src;
      cr_t         nxt;
      logic [51:0] delta;
      logic        take;

      if (j == 0) begin : g_first
        assign src = cr_init[c];
      end else begin : g_next
        assign src = cr_q[j-1][c];
      end

      // (y + 2^K)^3 - y^3 from shifts of y and y^2
      always_comb begin
        delta = ((52'(src.y2) + (52'(src.y2) << 1)) << K)
              + ((52'(src.y) + (52'(src.y) << 1)) << (2 * K))
              + (52'(1) << (3 * K));
        take  = (delta <= src.rem);
        nxt.sel = src.sel;
        nxt.y   = take ? (src.y | (17'(1) << K)) : src.y;
        nxt.y2  = take ? (src.y2 + (34'(src.y) << (K + 1)) + (34'(1) << (2 * K)))
                       : src.y2;
        nxt.rem = take ? (src.rem - delta) : src.rem;
      end

      always_ff @(posedge clk) begin
        if (en[ST_CR0+j]) begin
          cr_q[j][c] <= nxt;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Linear segment alongside the first cube root stages
  // --------------------------------------------------------------------------
  logic [28:0] lin_m [3];
  logic [58:0] lin_p [3];
  logic [14:0] lin_q [CR_STEPS-2][3];

  always_ff @(posedge clk) begin
    if (en[ST_CR0]) begin
      for (int c = 0; c < 3; c++) begin
        lin_m[c] <= 29'(xyz[c][9:0]) * LIN_SLOPE + LIN_OFFSET;
      end
    end
    if (en[ST_CR0+1]) begin
      for (int c = 0; c < 3; c++) begin
        lin_p[c] <= 59'(lin_m[c]) * 59'(LIN_RECIP);
      end
    end
    if (en[ST_CR0+2]) begin
      for (int c = 0; c < 3; c++) begin
        lin_q[0][c] <= lin_p[c][LIN_RSHIFT+14:LIN_RSHIFT];
      end
    end
    for (int j = 1; j < CR_STEPS - 2; j++) begin
      if (en[ST_CR0+2+j]) begin
        for (int c = 0; c < 3; c++) begin
          lin_q[j][c] <= lin_q[j-1][c];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Round the root to nearest and pick the branch
  // --------------------------------------------------------------------------
  logic [16:0] fv [3];

  always_ff @(posedge clk) begin
    if (en[ST_FIN]) begin
      for (int c = 0; c < 3; c++) begin
        if (cr_q[CR_STEPS-1][c].sel) begin
          fv[c] <= 17'(lin_q[CR_STEPS-3][c]);
        end else if ((56'(cr_q[CR_STEPS-1][c].rem) << 3)
                     >= ((56'(cr_q[CR_STEPS-1][c].y2) << 3)
                         + (56'(cr_q[CR_STEPS-1][c].y2) << 2)
                         + (56'(cr_q[CR_STEPS-1][c].y) << 2)
                         + (56'(cr_q[CR_STEPS-1][c].y) << 1)
                         + 56'd1)) begin
          fv[c] <= cr_q[CR_STEPS-1][c].y + 17'd1;
        end else begin
          fv[c] <= cr_q[CR_STEPS-1][c].y;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Differences, scaling, rounding, clamping
  // --------------------------------------------------------------------------
  logic [16:0]        fy_d;
  logic signed [17:0] da_d;
  logic signed [17:0] db_d;
  logic signed [26:0] lv_m;
  logic signed [26:0] av_m;
  logic signed [26:0] bv_m;
  logic signed [26:0] l_rnd;
  logic signed [26:0] a_rnd;
  logic signed [26:0] b_rnd;

  always_ff @(posedge clk) begin
    if (en[ST_DIFF]) begin
      fy_d <= fv[1];
      da_d <= $signed({1'b0, fv[0]}) - $signed({1'b0, fv[1]});
      db_d <= $signed({1'b0, fv[1]}) - $signed({1'b0, fv[2]});
    end
    if (en[ST_MUL]) begin
      lv_m <= $signed(27'(fy_d) * 27'd116) - 27'sd1048576;
      av_m <= 27'(da_d) * 27'sd500;
      bv_m <= 27'(db_d) * 27'sd200;
    end
    if (en[ST_RND]) begin
      l_rnd <= round_q(lv_m);
      a_rnd <= round_q(av_m);
      b_rnd <= round_q(bv_m);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      if (l_rnd < 27'sd0) begin
        lightness <= '0;
      end else if (l_rnd > L_MAX) begin
        lightness <= 15'(L_MAX);
      end else begin
        lightness <= 15'(l_rnd);
      end

      if (a_rnd < -27'sd32768) begin
        green_red_axis <= 16'sh8000;
      end else if (a_rnd > 27'sd32767) begin
        green_red_axis <= 16'sh7FFF;
      end else begin
        green_red_axis <= 16'(a_rnd);
      end

      if (b_rnd < -27'sd32768) begin
        blue_yellow_axis <= 16'sh8000;
      end else if (b_rnd > 27'sd32767) begin
        blue_yellow_axis <= 16'sh7FFF;
      end else begin
        blue_yellow_axis <= 16'(b_rnd);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A taken output beat always frees room for a new pixel
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    lab_ready |-> pix_ready)
    else $error("pixel stalled while output beat taken");

  // Full pipeline with a stalled output must not take a pixel
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    ((&vld) && !lab_ready) |-> !pix_ready)
    else $error("pixel accepted into a full pipeline");

  // f() stays inside its range after root rounding
  a_f_range: assert property (@(posedge clk) disable iff (rst)
    vld[ST_FIN] |-> (fv[0] <= F_MAX && fv[1] <= F_MAX && fv[2] <= F_MAX))
    else $error("f value out of range");

  // Lightness never above 100
  a_l_range: assert property (@(posedge clk) disable iff (rst)
    lab_valid |-> (27'(lightness) <= $unsigned(L_MAX)))
    else $error("lightness above 100");

endmodule

`default_nettype wire
